### design/mmft_pkg.sv
// shared constants and control/status structs for the mode frequency tracker
// used by mmft_ctrl, mmft_dp and the top level
`default_nettype none

package mmft_pkg;

  localparam int KEYS      = 4096;
  localparam int KEY_W     = 12;
  localparam int CNT_W     = 16;
  localparam int KPC_W     = 13;
  localparam int KPC_DEPTH = 65536;

  localparam logic [CNT_W-1:0] MAX_COUNT = 16'hFFFF;
  localparam logic [KEY_W-1:0] LAST_KEY  = KEY_W'(KEYS - 1);

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic lookup;
    logic upd1;
    logic upd2;
  } mmft_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clear_last;
  } mmft_status_t;

endpackage

`default_nettype wire

### design/mmft_ctrl.sv
// controller state machine: clearing pass, item acceptance and update sequencing
// depends on mmft_pkg
`default_nettype none

module mmft_ctrl
  import mmft_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  mmft_status_t      status,
  output mmft_cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_UPD1   = 5'b01000,
    S_UPD2   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // a new item may enter while the last write of the previous one finishes
  assign busy = !(state == S_IDLE || state == S_UPD2);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_LOOKUP;
      end
      S_LOOKUP: state_next = S_UPD1;
      S_UPD1:   state_next = S_UPD2;
      S_UPD2: begin
        state_next = start ? S_LOOKUP : S_IDLE;
      end
      default:  state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd.clear  = (state == S_CLEAR);
    cmd.load   = start && !busy;
    cmd.lookup = (state == S_LOOKUP);
    cmd.upd1   = (state == S_UPD1);
    cmd.upd2   = (state == S_UPD2);
  end

endmodule

`default_nettype wire

### design/mmft_dp.sv
// datapath: per-key count memory, count-of-counts memory, mode register, result registers
// depends on mmft_pkg; driven by mmft_ctrl
`default_nettype none

module mmft_dp
  import mmft_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  mmft_cmd_t             cmd,
  output mmft_status_t          status,
  input  wire logic             command,
  input  wire logic [KEY_W-1:0] key_index,
  output logic                  done,
  output logic [CNT_W-1:0]      mode_count,
  output logic                  error
);

  logic [CNT_W-1:0] kc_mem  [KEYS];
  logic [KPC_W-1:0] kpc_mem [KPC_DEPTH];

  logic [KEY_W-1:0] clr_addr;
  logic             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] kc_rd;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] addr1_q;
  logic             bad_q;
  logic [KPC_W-1:0] kpc_rd0;
  logic [KPC_W-1:0] kpc_rd1;
  logic [KPC_W-1:0] inc_q;
  logic [CNT_W-1:0] mode, mode_next;
  logic [CNT_W-1:0] hwm;

  logic             bad_c;
  logic [CNT_W-1:0] kc_new;
  logic [CNT_W-1:0] addr1_c;
  logic             valid0, valid1;
  logic [KPC_W-1:0] q0, q1;
  logic             kpc_we;
  logic [CNT_W-1:0] kpc_wa;
  logic [KPC_W-1:0] kpc_wd;

  // clearing pass over the key count memory after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + KEY_W'(1);
    end
  end

  assign status.clear_last = (clr_addr == LAST_KEY);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= command;
      key_q <= key_index;
    end
  end

  // lookup stage: key count is back from memory
  always_comb begin
    bad_c   = (cmd_q == CMD_REMOVE) ? (kc_rd == '0) : (kc_rd == MAX_COUNT);
    kc_new  = (cmd_q == CMD_REMOVE) ? kc_rd - CNT_W'(1) : kc_rd + CNT_W'(1);
    addr1_c = kc_new;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      kc_mem[clr_addr] <= '0;
    end else if (cmd.lookup && !bad_c) begin
      kc_mem[key_q] <= kc_new;
    end
    if (cmd.load) begin
      kc_rd <= kc_mem[key_index];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      cnt_q   <= kc_rd;
      addr1_q <= addr1_c;
      bad_q   <= bad_c;
    end
  end

  // entries above the highest mode seen since reset were never written and read as zero
  always_comb begin
    valid0 = (cnt_q != '0) && (cnt_q <= hwm);
    valid1 = (addr1_q != '0) && (addr1_q <= hwm);
    q0     = valid0 ? kpc_rd0 : '0;
    q1     = valid1 ? kpc_rd1 : '0;
  end

  always_comb begin
    mode_next = mode;
    if (!bad_q) begin
      if (cmd_q == CMD_ADD) begin
        if (cnt_q == mode) mode_next = mode + CNT_W'(1);
      end else begin
        if (cnt_q == mode && q0 == KPC_W'(1)) mode_next = mode - CNT_W'(1);
      end
    end
  end

  // one write port: old count entry in upd1, new count entry in upd2
  always_comb begin
    kpc_we = 1'b0;
    kpc_wa = cnt_q;
    kpc_wd = q0 - KPC_W'(1);
    if (cmd.upd1) begin
      kpc_we = !bad_q && (cnt_q != '0);
    end else if (cmd.upd2) begin
      kpc_we = !bad_q && (addr1_q != '0);
      kpc_wa = addr1_q;
      kpc_wd = inc_q;
    end
  end

  always_ff @(posedge clk) begin
    if (kpc_we) begin
      kpc_mem[kpc_wa] <= kpc_wd;
    end
    if (cmd.lookup) begin
      kpc_rd0 <= kpc_mem[kc_rd];
      kpc_rd1 <= kpc_mem[addr1_c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd1) begin
      inc_q <= q1 + KPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
      hwm  <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.upd1;
      if (cmd.upd1) begin
        mode <= mode_next;
        if (mode_next > hwm) hwm <= mode_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd1) begin
      mode_count <= mode_next;
      error      <= bad_q;
    end
  end

  // mode moves by at most one per beat
  a_mode_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (mode == $past(mode) || mode == $past(mode) + CNT_W'(1) ||
                     mode == $past(mode) - CNT_W'(1)))
    else $error("mode register moved by more than one");

  // an ignored item leaves the mode unchanged
  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    (done && error && !$past(rst)) |-> (mode_count == $past(mode)))
    else $error("ignored item changed the mode");

  // a result follows the first update cycle
  a_done_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.upd1 |=> done)
    else $error("result strobe missing after update");

endmodule

`default_nettype wire

### design/multiset_mode_frequency_tracker.sv
// top level of the multiset mode frequency tracker
// instantiates mmft_ctrl and mmft_dp; depends on mmft_pkg
`default_nettype none

// Usage:
//   An item (command, key_index) is taken at a rising edge where start is high
//   and busy is low. command 0 adds one occurrence of the key, 1 removes one.
//   Each item yields exactly one result beat: done is high for one cycle with
//   mode_count (largest occurrence count of any key) and error (item ignored:
//   remove of an absent key, or add to a key already at 65535).
//   The result follows the key count read, the count-of-counts read and the
//   first count-of-counts write; done is registered with that first write.
//   When start is held, items overlap: the next item is accepted in the cycle
//   its predecessor's result is shown. Item throughput is set by the single
//   write port of the count-of-counts memory, which takes two writes per item,
//   after two dependent synchronous reads.
//   Reset: synchronous, active high. After reset the key count memory is
//   swept to zero, one entry a cycle, with busy high. The count-of-counts
//   memory needs no sweep: entries above the highest mode seen since reset
//   read as zero.
//   The receiver cannot stall: each result must be taken in its done cycle.

module multiset_mode_frequency_tracker
  import mmft_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             command,
  input  wire logic [KEY_W-1:0] key_index,
  output logic                  done,
  output logic [CNT_W-1:0]      mode_count,
  output logic                  error
);

  mmft_cmd_t    cmd;
  mmft_status_t status;

  mmft_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  mmft_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .command    (command),
    .key_index  (key_index),
    .done       (done),
    .mode_count (mode_count),
    .error      (error)
  );

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for multiset_mode_frequency_tracker
// predicts mode count and error for every beat, depends on mmft_pkg and the rtl

module tb
  import mmft_pkg::*;
();

  typedef struct packed {
    logic [CNT_W-1:0] mode;
    logic             err;
  } mode_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             command = CMD_ADD;
  logic [KEY_W-1:0] key_index = '0;
  logic             busy;
  logic             done;
  logic [CNT_W-1:0] mode_count;
  logic             error;

  // predictor state
  logic [CNT_W-1:0] key_tally [KEYS];
  int               tally_population [KPC_DEPTH];
  logic [CNT_W-1:0] mode_now;

  mode_result_t pending_modes[$];
  int           fail_count;
  bit           gaps_on;

  multiset_mode_frequency_tracker i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .key_index  (key_index),
    .done       (done),
    .mode_count (mode_count),
    .error      (error)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t: mismatch: %s", $realtime, what);
  endtask

  function automatic mode_result_t track_item(input logic cmd, input logic [KEY_W-1:0] key);
    mode_result_t     res;
    logic [CNT_W-1:0] c;
    c       = key_tally[key];
    res.err = 1'b0;
    if (cmd == CMD_ADD) begin
      if (c == MAX_COUNT) begin
        res.err = 1'b1;
      end else begin
        if (c == mode_now) mode_now++;
        if (c != 0) tally_population[c]--;
        tally_population[c + 1]++;
        key_tally[key] = c + 1'b1;
      end
    end else begin
      if (c == 0) begin
        res.err = 1'b1;
      end else begin
        // mode only falls when the last key sitting at it drops
        if (c == mode_now && tally_population[c] == 1) mode_now--;
        tally_population[c]--;
        if (c != 1) tally_population[c - 1]++;
        key_tally[key] = c - 1'b1;
      end
    end
    res.mode = mode_now;
    return res;
  endfunction

  task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 33) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start     <= 1'b1;
    command   <= cmd;
    key_index <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_modes.push_back(track_item(cmd, key));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_modes.size() != 0) @(posedge clk);
  endtask

  // result checker, one beat per done cycle
  always @(posedge clk) begin
    mode_result_t want;
    if (!rst && done) begin
      if (pending_modes.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_modes.pop_front();
        if (mode_count !== want.mode)
          report_mismatch($sformatf("mode_count %0d, expected %0d", mode_count, want.mode));
        if (error !== want.err)
          report_mismatch($sformatf("error %b, expected %b", error, want.err));
      end
    end
  end

  task automatic test_field_extremes();
    gaps_on = 1'b1;
    send_item(CMD_REMOVE, 12'h000);   // remove of absent key on empty set
    send_item(CMD_REMOVE, LAST_KEY);
    send_item(CMD_ADD,    12'h000);
    send_item(CMD_ADD,    12'h000);
    send_item(CMD_ADD,    LAST_KEY);
    send_item(CMD_ADD,    LAST_KEY);
    send_item(CMD_ADD,    12'h555);
    send_item(CMD_ADD,    12'hAAA);
    send_item(CMD_REMOVE, 12'h000);   // another key still holds the mode
    send_item(CMD_REMOVE, LAST_KEY);  // last key at the mode leaves it
    send_item(CMD_REMOVE, 12'h000);
    send_item(CMD_REMOVE, 12'h000);   // now absent
    send_item(CMD_REMOVE, 12'h555);
    send_item(CMD_REMOVE, 12'hAAA);
    send_item(CMD_REMOVE, LAST_KEY);
    send_item(CMD_REMOVE, LAST_KEY);
    send_item(CMD_ADD,    12'hAAA);
    send_item(CMD_ADD,    12'hAAA);
    send_item(CMD_ADD,    12'hAAA);
    send_item(CMD_REMOVE, 12'hAAA);
    wait_for_results();
  endtask

  task automatic test_random_mix();
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] hot_base;
    int               remove_pct;
    hot_base = KEY_W'($urandom);
    for (int n = 0; n < 1250; n++) begin
      gaps_on = !(n >= 400 && n < 600);
      if (n == 800) wait_for_results();
      if (n % 250 == 0) hot_base = KEY_W'($urandom);
      // grow the multiset first, then drain it so the mode falls back
      remove_pct = (n < 700) ? 35 : 60;
      cmd = ($urandom_range(99) < remove_pct) ? CMD_REMOVE : CMD_ADD;
      if ($urandom_range(99) < 75) key = hot_base + KEY_W'($urandom_range(0, 11));
      else                         key = KEY_W'($urandom);
      send_item(cmd, key);
    end
    wait_for_results();
  endtask

  initial begin
    foreach (key_tally[k]) key_tally[k] = '0;
    foreach (tally_population[c]) tally_population[c] = 0;
    mode_now   = '0;
    fail_count = 0;
    gaps_on    = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_random_mix();

    repeat (12) @(posedge clk);
    if (pending_modes.size() != 0) report_mismatch("expected results never arrived");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(60_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
design/mmft_pkg.sv
design/mmft_ctrl.sv
design/mmft_dp.sv
design/multiset_mode_frequency_tracker.sv
verif/tb.sv
